// ===== design/tmrt_pkg.sv =====
// Shared types and constants for the time-of-day midnight rollover timestamper.
`timescale 1ns / 1ps
`default_nettype none
package tmrt_pkg;

  localparam int unsigned TodW   = 27;
  localparam int unsigned OffW   = 28;
  localparam int unsigned DayW   = 16;
  localparam int unsigned StampW = 43;
  localparam int unsigned SumW   = 30;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 28;

  localparam logic [TodW-1:0] DayMs     = 27'd86400000;
  localparam logic [TodW-1:0] HalfDayMs = 27'd43200000;
  localparam logic [TodW-1:0] NearMs    = 27'd300000;
  localparam logic [TodW-1:0] LateMs    = 27'd86100000;   // day minus near window
  localparam logic [TodW-1:0] FarMs     = 27'd600000;
  localparam logic [TodW-1:0] FarLateMs = 27'd85800000;   // day minus far window

  typedef enum logic [CfgIdxW-1:0] {
    RegOverrideEnable  = 3'd0,
    RegOverrideOffset  = 3'd1,
    RegIgnoreJumps     = 3'd2,
    RegResetDayPerFile = 3'd3,
    RegStartDay        = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                   override_enable;
    logic signed [OffW-1:0] override_offset_ms;
    logic                   ignore_jumps;
    logic                   reset_day_per_file;
    logic [DayW-1:0]        start_day;
  } cfg_t;

  // Item after rollover tracking, waiting to be turned into a timestamp
  typedef struct packed {
    logic            stamp_valid;
    logic [DayW-1:0] day;
    logic [TodW-1:0] tod;
    logic            day_advanced;
  } stamp_req_t;

endpackage
`default_nettype wire

// ===== design/tod_midnight_rollover_timestamper.sv =====
// An input transfer is registered in turn by the tracker, product and output registers.
// Throughput: one item per cycle through tracker, product and output registers, each with
// its own valid; a stalled output holds the input once all three stages are full.
// The day counters and rollover flags update in the cycle an item is transferred.
// Reset (rst_ni low, asynchronous) clears configuration, day counters, flags and all valids.
`timescale 1ns / 1ps
`default_nettype none
module tod_midnight_rollover_timestamper import tmrt_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                new_file_i,
  input  wire logic [TodW-1:0]     tod_ms_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     stamp_valid_o,
  output logic [StampW-1:0]        timestamp_ms_o,
  output logic                     day_advanced_o
);

  cfg_t       cfg;
  stamp_req_t req;
  logic       req_valid, req_ready;

  tmrt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tmrt_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .new_file_i  (new_file_i),
    .tod_ms_i    (tod_ms_i),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  tmrt_stamp u_stamp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_ready_o    (req_ready),
    .req_i          (req),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .stamp_valid_o  (stamp_valid_o),
    .timestamp_ms_o (timestamp_ms_o),
    .day_advanced_o (day_advanced_o)
  );

endmodule
`default_nettype wire

// ===== design/tmrt_cfg.sv =====
// Configuration register bank for the timestamper.
`timescale 1ns / 1ps
`default_nettype none
module tmrt_cfg import tmrt_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegOverrideEnable:  cfg_d.override_enable    = cfg_data_i[0];
        RegOverrideOffset:  cfg_d.override_offset_ms = $signed(cfg_data_i[OffW-1:0]);
        RegIgnoreJumps:     cfg_d.ignore_jumps       = cfg_data_i[0];
        RegResetDayPerFile: cfg_d.reset_day_per_file = cfg_data_i[0];
        RegStartDay:        cfg_d.start_day          = cfg_data_i[DayW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== design/tmrt_tracker.sv =====
// Offset wrap, range check and midnight rollover state; registers the day and time of day.
`timescale 1ns / 1ps
`default_nettype none
module tmrt_tracker import tmrt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            new_file_i,
  input  wire logic [TodW-1:0] tod_ms_i,
  output logic                 req_valid_o,
  input  wire logic            req_ready_i,
  output stamp_req_t           req_o
);

  logic            cur_day_en;
  logic [DayW-1:0] cur_day_q, cur_day_d;
  logic [DayW-1:0] prev_day_q, prev_day_d;
  logic            late_seen_q, late_seen_d;
  logic            recent_jump_q, recent_jump_d;
  logic            day_loaded_q;
  logic            req_valid_q, req_valid_d;
  stamp_req_t      req_q, req_d;

  logic                   in_fire;
  logic                   file_clr;
  logic                   late_eff, jump_eff, loaded_eff;
  logic [DayW-1:0]        cur_eff, prev_eff;
  logic signed [SumW-1:0] sum, adj;
  logic                   in_range;
  logic [TodW-1:0]        tod;
  logic                   early, invic, outside, late_now, jump_kept, advance;
  logic [DayW-1:0]        cur_next, prev_next;

  assign in_ready_o = !req_valid_q || req_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cur_day_en = in_fire;

  always_comb begin
    // New file handling and day load come before the range check
    file_clr   = new_file_i && cfg_i.reset_day_per_file;
    loaded_eff = day_loaded_q && !file_clr;
    late_eff   = late_seen_q && !file_clr;
    jump_eff   = recent_jump_q && !file_clr;
    cur_eff    = loaded_eff ? cur_day_q : cfg_i.start_day;
    prev_eff   = loaded_eff ? prev_day_q : cfg_i.start_day;

    sum = $signed({{(SumW-TodW){1'b0}}, tod_ms_i})
        + $signed({{(SumW-OffW){cfg_i.override_offset_ms[OffW-1]}}, cfg_i.override_offset_ms});
    adj = $signed({{(SumW-TodW){1'b0}}, tod_ms_i});
    if (cfg_i.override_enable) begin
      // single wrap only
      priority if (sum < 0) begin
        adj = sum + $signed({{(SumW-TodW){1'b0}}, DayMs});
      end else if (sum > $signed({{(SumW-TodW){1'b0}}, DayMs})) begin
        adj = sum - $signed({{(SumW-TodW){1'b0}}, DayMs});
      end else begin
        adj = sum;
      end
    end
    in_range = (adj >= 0) && (adj <= $signed({{(SumW-TodW){1'b0}}, DayMs}));
    tod      = adj[TodW-1:0];

    late_now  = tod >= LateMs;
    early     = tod <= NearMs;
    invic     = early || late_now;
    outside   = (tod > HalfDayMs) ? (tod <= FarLateMs) : (tod >= FarMs);
    jump_kept = jump_eff && !outside;
    advance   = !cfg_i.ignore_jumps && invic && !jump_kept && (late_eff || late_now) && early;
    cur_next  = advance ? cur_eff + 1'b1 : cur_eff;
    prev_next = advance ? cur_eff : prev_eff;

    cur_day_d     = cur_eff;
    prev_day_d    = prev_eff;
    late_seen_d   = late_eff;
    recent_jump_d = jump_eff;
    req_d         = '0;
    if (in_range) begin
      cur_day_d     = cur_next;
      prev_day_d    = prev_next;
      late_seen_d   = (late_eff || late_now) && !outside;
      recent_jump_d = (advance || jump_kept) && !outside;
      req_d.stamp_valid  = 1'b1;
      req_d.tod          = tod;
      req_d.day_advanced = advance;
      req_d.day = (!cfg_i.ignore_jumps && invic && !early) ? prev_next : cur_next;
    end

    req_valid_d = in_fire ? 1'b1 : (req_ready_i ? 1'b0 : req_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_day_q     <= '0;
      prev_day_q    <= '0;
      late_seen_q   <= 1'b0;
      recent_jump_q <= 1'b0;
      day_loaded_q  <= 1'b0;
      req_valid_q   <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      if (cur_day_en) begin
        cur_day_q     <= cur_day_d;
        prev_day_q    <= prev_day_d;
        late_seen_q   <= late_seen_d;
        recent_jump_q <= recent_jump_d;
        day_loaded_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= req_d;
    end
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

  a_adv_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && req_q.day_advanced |-> req_q.stamp_valid)
    else $error("rollover flagged on an out-of-range item");

  a_loaded_after_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> day_loaded_q)
    else $error("day not loaded after a transfer");

  a_adv_sets_jump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_range && advance |=>
      recent_jump_q && (cur_day_q == $past(cur_eff) + 1'b1) && (prev_day_q == $past(cur_eff)))
    else $error("rollover did not update day counters");

  a_invalid_keeps_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_range |=> late_seen_q == $past(late_eff) && recent_jump_q == $past(jump_eff))
    else $error("out-of-range item changed rollover flags");

endmodule
`default_nettype wire

// ===== design/tmrt_stamp.sv =====
// Timestamp datapath: day times milliseconds per day, then add time of day, into the output register.
`timescale 1ns / 1ps
`default_nettype none
module tmrt_stamp import tmrt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire stamp_req_t        req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   stamp_valid_o,
  output logic [StampW-1:0]      timestamp_ms_o,
  output logic                   day_advanced_o
);

  logic              mul_valid_q;
  logic [StampW-1:0] prod_q;
  logic [TodW-1:0]   tod_q;
  logic              sv_q, adv_q;
  logic              mul_ready;
  logic              out_valid_q;
  logic [StampW-1:0] ts_q;
  logic              osv_q, oadv_q;

  assign mul_ready   = !out_valid_q || out_ready_i;
  assign req_ready_o = !mul_valid_q || mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_ready_o) begin
        mul_valid_q <= req_valid_i;
      end
      if (mul_ready) begin
        out_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      prod_q <= StampW'(req_i.day) * StampW'(DayMs);
      tod_q  <= req_i.tod;
      sv_q   <= req_i.stamp_valid;
      adv_q  <= req_i.day_advanced;
    end
    if (mul_valid_q && mul_ready) begin
      ts_q   <= prod_q + StampW'(tod_q);
      osv_q  <= sv_q;
      oadv_q <= adv_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign stamp_valid_o  = osv_q;
  assign timestamp_ms_o = ts_q;
  assign day_advanced_o = oadv_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !osv_q |-> ts_q == '0 && !oadv_q)
    else $error("skipped item carries a non-zero result");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the time-of-day midnight rollover timestamper.
`timescale 1ns / 1ps
module tb;
  import tmrt_pkg::*;

  localparam longint DayL  = longint'(DayMs);
  localparam longint NearL = longint'(NearMs);
  localparam longint FarL  = longint'(FarMs);

  typedef struct packed {
    logic              stamp_valid;
    logic [StampW-1:0] timestamp_ms;
    logic              day_advanced;
  } stamp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic                new_file_i = 1'b0;
  logic [TodW-1:0]     tod_ms_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                stamp_valid_o;
  logic [StampW-1:0]   timestamp_ms_o;
  logic                day_advanced_o;

  tod_midnight_rollover_timestamper uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .new_file_i     (new_file_i),
    .tod_ms_i       (tod_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .stamp_valid_o  (stamp_valid_o),
    .timestamp_ms_o (timestamp_ms_o),
    .day_advanced_o (day_advanced_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies and rollover state of the predictor
  logic            cfg_override_en = 1'b0;
  longint          cfg_offset = 0;
  logic            cfg_ignore_jumps = 1'b0;
  logic            cfg_reload_per_file = 1'b0;
  logic [DayW-1:0] cfg_start_day = '0;
  logic [DayW-1:0] trk_cur_day = '0;
  logic [DayW-1:0] trk_prev_day = '0;
  logic            trk_late_seen = 1'b0;
  logic            trk_recent_jump = 1'b0;
  logic            trk_day_loaded = 1'b0;

  stamp_t      pending_stamps[$];
  int          mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  function automatic stamp_t predict_stamp(input logic nf, input logic [TodW-1:0] tod_raw);
    longint          t;
    longint          stamp;
    logic            early;
    logic            late;
    logic            outside;
    logic            advanced;
    logic [DayW-1:0] day;
    stamp_t          r;
    if (nf && cfg_reload_per_file) begin
      trk_day_loaded  = 1'b0;
      trk_late_seen   = 1'b0;
      trk_recent_jump = 1'b0;
    end
    // day load happens on arrival, even for an out-of-range item
    if (!trk_day_loaded) begin
      trk_cur_day    = cfg_start_day;
      trk_prev_day   = cfg_start_day;
      trk_day_loaded = 1'b1;
    end
    t = longint'(tod_raw);
    if (cfg_override_en) begin
      t = t + cfg_offset;
      if (t < 0) t = t + DayL;
      else if (t > DayL) t = t - DayL;
    end
    r = '0;
    if (t < 0 || t > DayL) return r;
    late = (t >= DayL - NearL);
    if (late) trk_late_seen = 1'b1;
    early = (t <= NearL);
    if (t > DayL / 2) outside = (t <= DayL - FarL);
    else outside = (t >= FarL);
    if (trk_recent_jump && outside) trk_recent_jump = 1'b0;
    advanced = 1'b0;
    day = trk_cur_day;
    if (!cfg_ignore_jumps && (early || late)) begin
      if (!trk_recent_jump && trk_late_seen && early) begin
        trk_cur_day     = trk_cur_day + 1'b1;
        trk_prev_day    = trk_cur_day - 1'b1;
        trk_recent_jump = 1'b1;
        advanced        = 1'b1;
      end
      day = early ? trk_cur_day : trk_prev_day;
    end
    if (outside) begin
      trk_recent_jump = 1'b0;
      trk_late_seen   = 1'b0;
    end
    stamp = longint'(day) * DayL + t;
    r.stamp_valid  = 1'b1;
    r.timestamp_ms = stamp[StampW-1:0];
    r.day_advanced = advanced;
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    stamp_t got;
    stamp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{stamp_valid_o, timestamp_ms_o, day_advanced_o};
      if (pending_stamps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result: valid %0b stamp %0d adv %0b",
                   $time, got.stamp_valid, got.timestamp_ms, got.day_advanced);
      end else begin
        want = pending_stamps.pop_front();
        if (got.stamp_valid !== want.stamp_valid || got.timestamp_ms !== want.timestamp_ms ||
            got.day_advanced !== want.day_advanced) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: expected valid %0b stamp %0d adv %0b, got %0b %0d %0b",
                     $time, want.stamp_valid, want.timestamp_ms, want.day_advanced,
                     got.stamp_valid, got.timestamp_ms, got.day_advanced);
        end
      end
    end
  end

  task automatic send_item(input logic nf, input logic [TodW-1:0] tod);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    new_file_i <= nf;
    tod_ms_i   <= tod;
    do @(posedge clk_i); while (!in_ready_o);
    pending_stamps.push_back(predict_stamp(nf, tod));
  endtask

  // drop valid and wait for every outstanding stamp to come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_stamps.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input longint value);
    logic signed [CfgDataW-1:0] off28;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegOverrideEnable:  cfg_override_en = value[0];
      RegOverrideOffset: begin
        off28 = value[CfgDataW-1:0];
        cfg_offset = longint'(off28);
      end
      RegIgnoreJumps:     cfg_ignore_jumps = value[0];
      RegResetDayPerFile: cfg_reload_per_file = value[0];
      RegStartDay:        cfg_start_day = value[DayW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Reset values; invalid items in between must not disturb the late flag
  task automatic test_reset_defaults();
    send_item(1'b0, '0);
    send_item(1'b0, DayMs);
    send_item(1'b0, DayMs + 27'd1);
    send_item(1'b0, '1);
    send_item(1'b0, '0);
    send_item(1'b0, LateMs);
  endtask

  task automatic test_rollover_windows();
    send_item(1'b0, NearMs);
    send_item(1'b0, NearMs + 27'd1);
    send_item(1'b0, FarMs - 27'd1);
    send_item(1'b0, FarMs);
    send_item(1'b0, FarLateMs);
    send_item(1'b0, FarLateMs + 27'd1);
    send_item(1'b0, LateMs - 27'd1);
    send_item(1'b0, LateMs);
    send_item(1'b0, NearMs);
  endtask

  task automatic test_offset_wrap();
    wait_idle();
    write_reg(RegOverrideEnable, 1);
    write_reg(RegOverrideOffset, -1000);
    send_item(1'b0, 27'd500);
    wait_idle();
    write_reg(RegOverrideOffset, DayL);
    send_item(1'b0, '0);
    send_item(1'b0, 27'd1);
    wait_idle();
    write_reg(RegOverrideOffset, 134217727);
    send_item(1'b0, '1);
    wait_idle();
    write_reg(RegOverrideOffset, -134217728);
    send_item(1'b0, '0);
    wait_idle();
    write_reg(RegOverrideOffset, -DayL);
    send_item(1'b0, '0);
    wait_idle();
    write_reg(RegOverrideEnable, 0);
  endtask

  task automatic test_ignore_jumps();
    wait_idle();
    write_reg(RegIgnoreJumps, 1);
    send_item(1'b0, DayMs - 27'd1);
    send_item(1'b0, 27'd1);
    wait_idle();
    write_reg(RegIgnoreJumps, 0);
  endtask

  // new file reloads the start day, also on an invalid item; day wraps past 65535
  task automatic test_file_reload();
    wait_idle();
    write_reg(RegResetDayPerFile, 1);
    write_reg(RegStartDay, 65535);
    send_item(1'b1, 27'd86200000);
    send_item(1'b0, 27'd100);
    send_item(1'b1, '1);
    send_item(1'b0, 27'd5);
  endtask

  task automatic test_random_traffic(input int n_items, input int unsigned tx_pct,
                                     input int unsigned rx_pct);
    longint      walk;
    longint      raw;
    longint      off;
    int unsigned pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    walk = DayL - 1000000;
    for (int seg = 0; seg < 4; seg++) begin
      wait_idle();
      write_reg(RegOverrideEnable, $urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: off = 0;
        1: off = DayL;
        2: off = -DayL;
        3: off = longint'($urandom_range(0, 172800000)) - DayL;
        4: off = longint'($urandom());
        default: off = longint'($urandom_range(0, 2000000)) - 1000000;
      endcase
      write_reg(RegOverrideOffset, off);
      write_reg(RegIgnoreJumps, ($urandom_range(0, 3) == 0));
      write_reg(RegResetDayPerFile, $urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: write_reg(RegStartDay, 0);
        1: write_reg(RegStartDay, 65535);
        2: write_reg(RegStartDay, 65534);
        default: write_reg(RegStartDay, $urandom_range(0, 65535));
      endcase
      for (int k = 0; k < n_items / 4; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          raw = longint'($urandom() & 32'h07FF_FFFF);
        end else if (pick < 18) begin
          raw = longint'($urandom_range(0, 86400000));
        end else begin
          // clock walking across midnight, with the odd step backwards
          if ((walk > 1000000 && walk < DayL - 1500000) || $urandom_range(0, 19) == 0)
            walk = DayL - longint'($urandom_range(0, 1500000));
          else if ($urandom_range(0, 19) == 0)
            walk = walk - longint'($urandom_range(0, 400000));
          else
            walk = walk + longint'($urandom_range(0, 250000));
          if (walk < 0) walk = 0;
          if (walk > DayL) walk = walk - DayL;
          raw = walk;
          if (cfg_override_en) raw = ((walk - cfg_offset) % DayL + DayL) % DayL;
        end
        send_item(($urandom_range(0, 99) < 4), raw[TodW-1:0]);
      end
    end
  endtask

  initial begin
    tx_idle_pct = 12;
    rx_idle_pct = 48;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_rollover_windows();
    test_offset_wrap();
    test_ignore_jumps();
    test_file_reload();
    test_random_traffic(260, 12, 48);
    test_random_traffic(260, 48, 12);
    test_random_traffic(260, 0, 0);
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0)
      $display("tod_midnight_rollover_timestamper regression: pass");
    else
      $display("tod_midnight_rollover_timestamper regression: fail");
    $finish;
  end

  initial begin
    #2000000;
    $display("tod_midnight_rollover_timestamper regression: fail");
    $finish;
  end

endmodule
